// ===== src/rsc_pkg.sv =====
// Shared types and constants of the RPN stack calculator.
// Holds opcodes, status codes and the command/status structs between
// the controller and the datapath; depends on nothing.
package rsc_pkg;

    localparam int DATA_W      = 32;
    localparam int MAX_RESULTS = 16;
    localparam int SHOW_W      = $clog2(MAX_RESULTS + 1);
    localparam int DIV_STEPS   = DATA_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    typedef enum logic [3:0] {
        OP_PUSH  = 4'd0,
        OP_TOP   = 4'd1,
        OP_POP   = 4'd2,
        OP_ALL   = 4'd3,
        OP_CLEAR = 4'd4,
        OP_DUP   = 4'd5,
        OP_SWAP  = 4'd6,
        OP_ADD   = 4'd7,
        OP_SUB   = 4'd8,
        OP_MUL   = 4'd9,
        OP_DIV   = 4'd10,
        OP_REM   = 4'd11
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_DIVZ  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        RD_TOP    = 2'd0,
        RD_SECOND = 2'd1,
        RD_IDX    = 2'd2
    } rd_sel_t;

    typedef enum logic [1:0] {
        WA_COUNT  = 2'd0,
        WA_TOP    = 2'd1,
        WA_SECOND = 2'd2
    } wa_sel_t;

    typedef enum logic [2:0] {
        WD_PUSH = 3'd0,
        WD_MEMQ = 3'd1,
        WD_A    = 3'd2,
        WD_B    = 3'd3,
        WD_RES  = 3'd4
    } wd_sel_t;

    typedef enum logic [1:0] {
        CNT_HOLD = 2'd0,
        CNT_INC  = 2'd1,
        CNT_DEC  = 2'd2,
        CNT_CLR  = 2'd3
    } cnt_op_t;

    typedef struct packed {
        logic    load;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wa_sel_t wa_sel;
        wd_sel_t wd_sel;
        cnt_op_t cnt_op;
        logic    ld_a;
        logic    ld_b;
        logic    ld_res;
        logic    div_start;
        logic    list_init;
        logic    list_step;
        logic    emit;
        logic    emit_has;
        status_t emit_status;
        logic    emit_last;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic empty;
        logic lt2;
        logic full;
        logic b_zero;
        logic div_done;
        logic list_last;
    } sts_t;

endpackage

// ===== src/rsc_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Uses rsc_pkg for widths.
module rsc_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [rsc_pkg::DATA_W-1:0] dividend,
    input  logic [rsc_pkg::DATA_W-1:0] divisor,
    output logic [rsc_pkg::DATA_W-1:0] quotient,
    output logic [rsc_pkg::DATA_W-1:0] remainder,
    output logic                       done
);
    localparam int W = rsc_pkg::DATA_W;

    logic                           run_reg;
    logic                           done_reg;
    logic [rsc_pkg::DIV_CNT_W-1:0]  step_reg;
    logic [W-1:0]                   quo_reg;
    logic [W-1:0]                   rem_reg;
    logic [W-1:0]                   dvs_reg;
    logic                           neg_q_reg;
    logic                           neg_r_reg;

    logic [W-1:0] dividend_mag;
    logic [W-1:0] divisor_mag;
    logic [W:0]   shifted;
    logic [W:0]   diff;

    assign dividend_mag = dividend[W-1] ? (~dividend + W'(1)) : dividend;
    assign divisor_mag  = divisor[W-1] ? (~divisor + W'(1)) : divisor;
    assign shifted      = {rem_reg, quo_reg[W-1]};
    assign diff         = shifted - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end else if (run_reg) begin
                step_reg <= step_reg + rsc_pkg::DIV_CNT_W'(1);
                if (step_reg == rsc_pkg::DIV_CNT_W'(rsc_pkg::DIV_STEPS - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (start) begin
            quo_reg   <= dividend_mag;
            rem_reg   <= '0;
            dvs_reg   <= divisor_mag;
            neg_q_reg <= dividend[W-1] ^ divisor[W-1];
            neg_r_reg <= dividend[W-1];
        end else if (run_reg) begin
            // restore when the trial subtract goes negative
            rem_reg <= diff[W] ? shifted[W-1:0] : diff[W-1:0];
            quo_reg <= {quo_reg[W-2:0], ~diff[W]};
        end
    end

    assign quotient  = neg_q_reg ? (~quo_reg + W'(1)) : quo_reg;
    assign remainder = neg_r_reg ? (~rem_reg + W'(1)) : rem_reg;
    assign done      = done_reg;

endmodule

// ===== src/rsc_datapath.sv =====
// Datapath of the RPN stack calculator: stack memory, count, operand and
// result registers, divider and result output registers. Uses rsc_pkg, rsc_div.
module rsc_datapath #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [3:0]                 operation,
    input  logic [rsc_pkg::DATA_W-1:0] push_value,
    input  rsc_pkg::cmd_t              cmd,
    output rsc_pkg::sts_t              sts,
    output logic                       strobe,
    output logic                       has_value,
    output logic [rsc_pkg::DATA_W-1:0] out_value,
    output logic [1:0]                 status,
    output logic                       last
);
    localparam int W      = rsc_pkg::DATA_W;
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int SHOW_W = rsc_pkg::SHOW_W;

    logic [W-1:0] mem [STACK_DEPTH];

    rsc_pkg::op_t     op_reg;
    logic [W-1:0]     pv_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W-1:0]     mem_q_reg;
    logic [W-1:0]     a_reg;
    logic [W-1:0]     b_reg;
    logic [W-1:0]     res_reg;
    logic [ADDR_W-1:0] idx_reg;
    logic [SHOW_W-1:0] left_reg;

    logic                strobe_reg;
    logic                has_value_reg;
    logic [W-1:0]        out_value_reg;
    rsc_pkg::status_t    status_reg;
    logic                last_reg;

    logic [CNT_W-1:0]  cnt_m1;
    logic [CNT_W-1:0]  cnt_m2;
    logic [ADDR_W-1:0] raddr;
    logic [ADDR_W-1:0] waddr;
    logic [W-1:0]      wdata;
    logic [W-1:0]      alu_res;
    logic [SHOW_W-1:0] shown;
    logic [W-1:0]      div_q;
    logic [W-1:0]      div_r;
    logic              div_done;

    assign cnt_m1 = cnt_reg - CNT_W'(1);
    assign cnt_m2 = cnt_reg - CNT_W'(2);
    assign shown  = (int'(cnt_reg) > rsc_pkg::MAX_RESULTS)
                    ? SHOW_W'(rsc_pkg::MAX_RESULTS) : SHOW_W'(cnt_reg);

    always_comb begin
        unique case (cmd.rd_sel)
            rsc_pkg::RD_TOP:    raddr = cnt_m1[ADDR_W-1:0];
            rsc_pkg::RD_SECOND: raddr = cnt_m2[ADDR_W-1:0];
            rsc_pkg::RD_IDX:    raddr = idx_reg;
            default:            raddr = idx_reg;
        endcase
        unique case (cmd.wa_sel)
            rsc_pkg::WA_COUNT:  waddr = cnt_reg[ADDR_W-1:0];
            rsc_pkg::WA_TOP:    waddr = cnt_m1[ADDR_W-1:0];
            rsc_pkg::WA_SECOND: waddr = cnt_m2[ADDR_W-1:0];
            default:            waddr = cnt_m2[ADDR_W-1:0];
        endcase
        unique case (cmd.wd_sel)
            rsc_pkg::WD_PUSH: wdata = pv_reg;
            rsc_pkg::WD_MEMQ: wdata = mem_q_reg;
            rsc_pkg::WD_A:    wdata = a_reg;
            rsc_pkg::WD_B:    wdata = b_reg;
            rsc_pkg::WD_RES:  wdata = res_reg;
            default:          wdata = res_reg;
        endcase
        unique case (op_reg)
            rsc_pkg::OP_ADD: alu_res = a_reg + b_reg;
            rsc_pkg::OP_SUB: alu_res = a_reg - b_reg;
            rsc_pkg::OP_MUL: alu_res = a_reg * b_reg;
            rsc_pkg::OP_DIV: alu_res = div_q;
            rsc_pkg::OP_REM: alu_res = div_r;
            default:         alu_res = '0;
        endcase
    end

    rsc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (a_reg),
        .divisor   (b_reg),
        .quotient  (div_q),
        .remainder (div_r),
        .done      (div_done)
    );

    // stack memory and payload registers
    always_ff @(posedge clk) begin
        if (cmd.wr_en) begin
            mem[waddr] <= wdata;
        end
        if (cmd.rd_en) begin
            mem_q_reg <= mem[raddr];
        end
        if (cmd.load) begin
            op_reg <= rsc_pkg::op_t'(operation);
            pv_reg <= push_value;
        end
        if (cmd.ld_a) begin
            a_reg <= mem_q_reg;
        end
        if (cmd.ld_b) begin
            b_reg <= mem_q_reg;
        end
        if (cmd.ld_res) begin
            res_reg <= alu_res;
        end
        if (cmd.emit) begin
            has_value_reg <= cmd.emit_has;
            out_value_reg <= cmd.emit_has ? mem_q_reg : '0;
            status_reg    <= cmd.emit_status;
            last_reg      <= cmd.emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cnt_reg    <= '0;
            idx_reg    <= '0;
            left_reg   <= '0;
            strobe_reg <= 1'b0;
        end else begin
            strobe_reg <= cmd.emit;
            unique case (cmd.cnt_op)
                rsc_pkg::CNT_HOLD: cnt_reg <= cnt_reg;
                rsc_pkg::CNT_INC:  cnt_reg <= cnt_reg + CNT_W'(1);
                rsc_pkg::CNT_DEC:  cnt_reg <= cnt_m1;
                rsc_pkg::CNT_CLR:  cnt_reg <= '0;
                default:           cnt_reg <= cnt_reg;
            endcase
            if (cmd.list_init) begin
                idx_reg  <= cnt_m1[ADDR_W-1:0];
                left_reg <= shown;
            end else if (cmd.list_step) begin
                idx_reg  <= idx_reg - ADDR_W'(1);
                left_reg <= left_reg - SHOW_W'(1);
            end
        end
    end

    assign sts.op        = op_reg;
    assign sts.empty     = (cnt_reg == '0);
    assign sts.lt2       = (cnt_reg < CNT_W'(2));
    assign sts.full      = (cnt_reg == CNT_W'(STACK_DEPTH));
    assign sts.b_zero    = (b_reg == '0);
    assign sts.div_done  = div_done;
    assign sts.list_last = (left_reg == SHOW_W'(1));

    assign strobe    = strobe_reg;
    assign has_value = has_value_reg;
    assign out_value = out_value_reg;
    assign status    = status_reg;
    assign last      = last_reg;

endmodule

// ===== src/rsc_ctrl.sv =====
// Controller of the RPN stack calculator: one-hot state machine that
// sequences stack reads, writes, arithmetic and result output. Uses rsc_pkg.
module rsc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  rsc_pkg::sts_t sts,
    output rsc_pkg::cmd_t cmd
);
    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_DECODE   = 12'b0000_0000_0010,
        S_PRINT    = 12'b0000_0000_0100,
        S_LIST_RD  = 12'b0000_0000_1000,
        S_LIST_OUT = 12'b0000_0001_0000,
        S_DUP_WR   = 12'b0000_0010_0000,
        S_FETCH_B  = 12'b0000_0100_0000,
        S_FETCH_A  = 12'b0000_1000_0000,
        S_EXEC     = 12'b0001_0000_0000,
        S_DIV_WAIT = 12'b0010_0000_0000,
        S_WRITE    = 12'b0100_0000_0000,
        S_SWAP_WR  = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                // single-result commands finish here unless they need the memory
                cmd.emit_last = 1'b1;
                state_next    = S_IDLE;
                unique case (sts.op)
                    rsc_pkg::OP_PUSH:
                    begin
                        cmd.emit = 1'b1;
                        if (sts.full)
                        begin
                            cmd.emit_status = rsc_pkg::ST_OVER;
                        end
                        else
                        begin
                            cmd.wr_en  = 1'b1;
                            cmd.wa_sel = rsc_pkg::WA_COUNT;
                            cmd.wd_sel = rsc_pkg::WD_PUSH;
                            cmd.cnt_op = rsc_pkg::CNT_INC;
                        end
                    end
                    rsc_pkg::OP_TOP, rsc_pkg::OP_POP:
                    begin
                        if (sts.empty)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = rsc_pkg::ST_UNDER;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = rsc_pkg::RD_TOP;
                            state_next = S_PRINT;
                        end
                    end
                    rsc_pkg::OP_ALL:
                    begin
                        if (sts.empty)
                        begin
                            cmd.emit = 1'b1;
                        end
                        else
                        begin
                            cmd.list_init = 1'b1;
                            state_next    = S_LIST_RD;
                        end
                    end
                    rsc_pkg::OP_CLEAR:
                    begin
                        cmd.emit   = 1'b1;
                        cmd.cnt_op = rsc_pkg::CNT_CLR;
                    end
                    rsc_pkg::OP_DUP:
                    begin
                        if (sts.empty)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = rsc_pkg::ST_UNDER;
                        end
                        else if (sts.full)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = rsc_pkg::ST_OVER;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = rsc_pkg::RD_TOP;
                            state_next = S_DUP_WR;
                        end
                    end
                    rsc_pkg::OP_SWAP, rsc_pkg::OP_ADD, rsc_pkg::OP_SUB,
                    rsc_pkg::OP_MUL, rsc_pkg::OP_DIV, rsc_pkg::OP_REM:
                    begin
                        if (sts.lt2)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = rsc_pkg::ST_UNDER;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = rsc_pkg::RD_TOP;
                            state_next = S_FETCH_B;
                        end
                    end
                    default:
                    begin
                        cmd.emit = 1'b1;
                    end
                endcase
            end
            S_PRINT:
            begin
                cmd.emit      = 1'b1;
                cmd.emit_has  = 1'b1;
                cmd.emit_last = 1'b1;
                if (sts.op == rsc_pkg::OP_POP)
                begin
                    cmd.cnt_op = rsc_pkg::CNT_DEC;
                end
                state_next = S_IDLE;
            end
            S_LIST_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = rsc_pkg::RD_IDX;
                state_next = S_LIST_OUT;
            end
            S_LIST_OUT:
            begin
                cmd.emit      = 1'b1;
                cmd.emit_has  = 1'b1;
                cmd.emit_last = sts.list_last;
                if (sts.list_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.list_step = 1'b1;
                    state_next    = S_LIST_RD;
                end
            end
            S_DUP_WR:
            begin
                cmd.wr_en     = 1'b1;
                cmd.wa_sel    = rsc_pkg::WA_COUNT;
                cmd.wd_sel    = rsc_pkg::WD_MEMQ;
                cmd.cnt_op    = rsc_pkg::CNT_INC;
                cmd.emit      = 1'b1;
                cmd.emit_last = 1'b1;
                state_next    = S_IDLE;
            end
            S_FETCH_B:
            begin
                cmd.ld_b   = 1'b1;
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = rsc_pkg::RD_SECOND;
                state_next = S_FETCH_A;
            end
            S_FETCH_A:
            begin
                cmd.ld_a   = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                unique case (sts.op)
                    rsc_pkg::OP_SWAP:
                    begin
                        cmd.wr_en  = 1'b1;
                        cmd.wa_sel = rsc_pkg::WA_TOP;
                        cmd.wd_sel = rsc_pkg::WD_A;
                        state_next = S_SWAP_WR;
                    end
                    rsc_pkg::OP_DIV, rsc_pkg::OP_REM:
                    begin
                        if (sts.b_zero)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = rsc_pkg::ST_DIVZ;
                            cmd.emit_last   = 1'b1;
                            state_next      = S_IDLE;
                        end
                        else
                        begin
                            cmd.div_start = 1'b1;
                            state_next    = S_DIV_WAIT;
                        end
                    end
                    default:
                    begin
                        cmd.ld_res = 1'b1;
                        state_next = S_WRITE;
                    end
                endcase
            end
            S_DIV_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.ld_res = 1'b1;
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                cmd.wr_en     = 1'b1;
                cmd.wa_sel    = rsc_pkg::WA_SECOND;
                cmd.wd_sel    = rsc_pkg::WD_RES;
                cmd.cnt_op    = rsc_pkg::CNT_DEC;
                cmd.emit      = 1'b1;
                cmd.emit_last = 1'b1;
                state_next    = S_IDLE;
            end
            S_SWAP_WR:
            begin
                cmd.wr_en     = 1'b1;
                cmd.wa_sel    = rsc_pkg::WA_SECOND;
                cmd.wd_sel    = rsc_pkg::WD_B;
                cmd.emit      = 1'b1;
                cmd.emit_last = 1'b1;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/rpn_stack_calculator.sv =====
// RPN stack calculator, top level: controller plus datapath with stack memory.
// Push, clear and status-only items finish in decode; print and dup first read the top
// entry; swap and the arithmetic ops fetch both operands, and div/rem then wait on the
// divider unless divisor is zero. Print all reads then outputs each entry (one read port).
// The next item may be accepted in the cycle that carries the final result. Reset (rst_n,
// async) empties the stack; stack words stay undefined until written. No output stall.
module rpn_stack_calculator #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [3:0]          operation,
    input  logic signed [31:0]  push_value,
    output logic                strobe,
    output logic                has_value,
    output logic signed [31:0]  out_value,
    output logic [1:0]          status,
    output logic                last
);
    // Command and status buses between the sequencer and the datapath
    rsc_pkg::cmd_t cmd;
    rsc_pkg::sts_t sts;

    logic [31:0] out_value_raw;

    // The controller accepts an item while idle, then walks the stack accesses at most
    // one memory port operation per cycle, and waits while the divider runs.
    rsc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    // The datapath holds the stack memory, the entry count, operand and
    // result registers, the divider and the registered result outputs.
    rsc_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .operation  (operation),
        .push_value (push_value),
        .cmd        (cmd),
        .sts        (sts),
        .strobe     (strobe),
        .has_value  (has_value),
        .out_value  (out_value_raw),
        .status     (status),
        .last       (last)
    );

    assign out_value = out_value_raw;

`ifndef SYNTHESIS
    // An accepted item keeps the block busy in the following cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after an accepted item");

    // The final result of an item appears only once the controller is idle again
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |-> !busy)
        else $error("final result while controller still busy");

    // An error result never carries a value and always ends the item
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && status != rsc_pkg::ST_OK |-> !has_value && last)
        else $error("error result with value or without last");

    // A result without a value prints zero
    a_novalue_zero: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !has_value |-> out_value == '0)
        else $error("nonzero value on a result without a value");
`endif

endmodule

// ===== verif/tb_rpn_stack_calculator.sv =====
// Self-checking testbench for the RPN stack calculator (rpn_stack_calculator).
// Depends on rsc_pkg for opcodes, status codes and MAX_RESULTS, and on the design under
// test. A built-in stack predictor supplies the expected results for each item.
`timescale 1ns / 1ps

module tb_rpn_stack_calculator;

    localparam int DEPTH         = 16;
    localparam int IDX_W         = $clog2(DEPTH);
    localparam int CYCLE_LIMIT   = 200_000;
    localparam int DRAIN_LIMIT   = 4_000;
    // Longest item is div/rem; leave margin before the final check.
    localparam int SETTLE_CYCLES = 60;
    localparam int MAX_REPORTS   = 40;

    // Operation codes that the block decodes as no-ops.
    localparam logic [3:0]  OP_SPARE_LO = 4'd12;
    localparam logic [3:0]  OP_SPARE_HI = 4'd15;

    localparam logic [31:0] MIN_VAL     = 32'h8000_0000;
    localparam logic [31:0] MAX_VAL     = 32'h7FFF_FFFF;
    localparam logic [31:0] MINUS_ONE   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic              has;
        logic [31:0]       val;
        rsc_pkg::status_t  st;
        logic              lst;
    } calc_result_t;

    logic               clk;
    logic               rst_n      = 1'b0;
    logic               start      = 1'b0;
    logic [3:0]         operation  = '0;
    logic signed [31:0] push_value = '0;
    logic               busy;
    logic               strobe;
    logic               has_value;
    logic signed [31:0] out_value;
    logic [1:0]         status;
    logic               last;

    // Predictor state: a private copy of the stack, updated when an item is taken.
    logic [31:0]        model_stack [DEPTH];
    int unsigned        model_depth = 0;
    calc_result_t       expected_results [$];
    calc_result_t       want;

    int sender_idle_pct = 0;
    int cycle_count     = 0;
    int error_count     = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int error_results   = 0;
    int fill_bursts     = 0;

    rpn_stack_calculator #(
        .STACK_DEPTH (DEPTH)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .operation  (operation),
        .push_value (push_value),
        .strobe     (strobe),
        .has_value  (has_value),
        .out_value  (out_value),
        .status     (status),
        .last       (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Free-running cycle counter; end the run if the block stops making progress.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still pending",
                     cycle_count, expected_results.size());
            $display("rpn_stack_calculator test failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        if (error_count < MAX_REPORTS)
            $display("[%0t] MISMATCH at result %0d: %s got 0x%08h want 0x%08h",
                     $realtime, results_checked, what, got, exp_val);
        error_count++;
    endtask

    // Queue one expected result for the item just taken.
    function automatic void expect_result(input logic has, input logic [31:0] val,
                                          input rsc_pkg::status_t st, input logic lst);
        calc_result_t r;
        r.has = has;
        r.val = has ? val : '0;
        r.st  = st;
        r.lst = lst;
        expected_results.push_back(r);
        if (st != rsc_pkg::ST_OK)
            error_results++;
    endfunction

    // Apply one command to the predicted stack and queue the results it produces.
    function automatic void calc_apply(input logic [3:0] op, input logic [31:0] value);
        int unsigned      n;
        int unsigned      shown;
        int               i;
        logic [31:0]      a;
        logic [31:0]      b;
        logic [31:0]      r;
        longint           sa;
        longint           sb;
        rsc_pkg::status_t st;
        logic             printed;

        n       = model_depth;
        st      = rsc_pkg::ST_OK;
        printed = 1'b0;
        items_sent++;

        case (op)
            rsc_pkg::OP_PUSH:
                if (n >= DEPTH)
                    st = rsc_pkg::ST_OVER;
                else
                begin
                    model_stack[IDX_W'(n)] = value;
                    model_depth            = n + 1;
                end
            rsc_pkg::OP_TOP, rsc_pkg::OP_POP:
                if (n < 1)
                    st = rsc_pkg::ST_UNDER;
                else
                begin
                    expect_result(1'b1, model_stack[IDX_W'(n - 1)], rsc_pkg::ST_OK, 1'b1);
                    if (op == rsc_pkg::OP_POP)
                        model_depth = n - 1;
                    printed = 1'b1;
                end
            rsc_pkg::OP_ALL:
                if (n > 0)
                begin
                    // Top down, capped at the topmost MAX_RESULTS entries.
                    shown = (n < rsc_pkg::MAX_RESULTS) ? n : rsc_pkg::MAX_RESULTS;
                    for (i = 0; i < shown; i++)
                        expect_result(1'b1, model_stack[IDX_W'(n - 1 - i)],
                                      rsc_pkg::ST_OK, i + 1 == shown);
                    printed = 1'b1;
                end
            rsc_pkg::OP_CLEAR:
                model_depth = 0;
            rsc_pkg::OP_DUP:
                if (n < 1)
                    st = rsc_pkg::ST_UNDER;
                else if (n >= DEPTH)
                    st = rsc_pkg::ST_OVER;
                else
                begin
                    model_stack[IDX_W'(n)] = model_stack[IDX_W'(n - 1)];
                    model_depth            = n + 1;
                end
            rsc_pkg::OP_SWAP, rsc_pkg::OP_ADD, rsc_pkg::OP_SUB,
            rsc_pkg::OP_MUL, rsc_pkg::OP_DIV, rsc_pkg::OP_REM:
                if (n < 2)
                    st = rsc_pkg::ST_UNDER;
                else
                begin
                    // Left operand is second from top, right operand is the top.
                    b = model_stack[IDX_W'(n - 1)];
                    a = model_stack[IDX_W'(n - 2)];
                    if (op == rsc_pkg::OP_SWAP)
                    begin
                        model_stack[IDX_W'(n - 1)] = a;
                        model_stack[IDX_W'(n - 2)] = b;
                    end
                    else if ((op == rsc_pkg::OP_DIV || op == rsc_pkg::OP_REM) && b == '0)
                        st = rsc_pkg::ST_DIVZ;
                    else
                    begin
                        // 64-bit signed divide truncates toward zero and cannot
                        // overflow, so MIN / -1 wraps back to MIN once truncated.
                        sa = longint'($signed(a));
                        sb = longint'($signed(b));
                        case (op)
                            rsc_pkg::OP_ADD: r = a + b;
                            rsc_pkg::OP_SUB: r = a - b;
                            rsc_pkg::OP_MUL: r = a * b;
                            rsc_pkg::OP_DIV: r = 32'(sa / sb);
                            default:         r = 32'(sa % sb);
                        endcase
                        model_stack[IDX_W'(n - 2)] = r;
                        model_depth                = n - 1;
                    end
                end
            default: ;
        endcase

        if (!printed)
            expect_result(1'b0, '0, st, 1'b1);
    endfunction

    // Present one item, hold it until the block takes it, then predict its results.
    // A gap before the item drops start; back-to-back items keep it high.
    task automatic send_command(input logic [3:0] op, input logic [31:0] value);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start      <= 1'b1;
        operation  <= op;
        push_value <= value;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        calc_apply(op, value);
    endtask

    // Results cannot be held off: check every strobe against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && strobe === 1'b1)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result, out_value", out_value, '0);
            else
            begin
                want = expected_results.pop_front();
                if (has_value !== want.has)
                    report_mismatch("has_value", 32'(has_value), 32'(want.has));
                if (out_value !== want.val)
                    report_mismatch("out_value", out_value, want.val);
                if (status !== want.st)
                    report_mismatch("status", 32'(status), 32'(want.st));
                if (last !== want.lst)
                    report_mismatch("last", 32'(last), 32'(want.lst));
            end
            results_checked++;
        end
    end

    // Mostly extremes and small values, so divides see zero and minus one often.
    function automatic logic [31:0] pick_value();
        int k;
        int s;
        k = $urandom_range(9);
        s = $urandom_range(16);
        case (k)
            0:       return MIN_VAL;
            1:       return MAX_VAL;
            2:       return '0;
            3:       return MINUS_ONE;
            4, 5, 6: return 32'(s - 8);
            default: return $urandom();
        endcase
    endfunction

    // Drive the stack to its full depth, then hit overflow and print it all.
    task automatic fill_stack();
        while (model_depth < DEPTH)
            send_command(rsc_pkg::OP_PUSH, pick_value());
        send_command(rsc_pkg::OP_PUSH, pick_value());
        send_command(rsc_pkg::OP_DUP, '0);
        send_command(rsc_pkg::OP_ALL, '0);
        fill_bursts++;
    endtask

    task automatic test_empty_stack();
        send_command(OP_SPARE_HI, MAX_VAL);
        send_command(rsc_pkg::OP_TOP, '0);
        send_command(rsc_pkg::OP_POP, '0);
        send_command(rsc_pkg::OP_DUP, '0);
        send_command(rsc_pkg::OP_ALL, '0);
    endtask

    task automatic test_wrap_and_min_divide();
        send_command(rsc_pkg::OP_PUSH, MAX_VAL);
        send_command(rsc_pkg::OP_SWAP, '0);     // one operand only: underflow
        send_command(rsc_pkg::OP_PUSH, 32'd1);
        send_command(rsc_pkg::OP_ADD, '0);      // wraps to the most negative value
        send_command(rsc_pkg::OP_TOP, '0);
        send_command(rsc_pkg::OP_PUSH, MINUS_ONE);
        send_command(rsc_pkg::OP_DIV, '0);      // MIN / -1 stays MIN
        send_command(rsc_pkg::OP_PUSH, MINUS_ONE);
        send_command(rsc_pkg::OP_REM, '0);      // MIN % -1 is zero
    endtask

    task automatic test_divide_by_zero();
        send_command(rsc_pkg::OP_PUSH, 32'hFFFF_FFF9);   // -7
        send_command(rsc_pkg::OP_SWAP, '0);              // zero now on top
        send_command(rsc_pkg::OP_DIV, '0);
        send_command(rsc_pkg::OP_REM, '0);
        send_command(rsc_pkg::OP_POP, '0);
    endtask

    task automatic test_signed_ops();
        send_command(rsc_pkg::OP_DUP, '0);
        send_command(rsc_pkg::OP_PUSH, 32'd2);
        send_command(rsc_pkg::OP_REM, '0);      // -7 % 2 = -1, sign of the dividend
        send_command(rsc_pkg::OP_MUL, '0);
        send_command(rsc_pkg::OP_PUSH, MIN_VAL);
        send_command(rsc_pkg::OP_SUB, '0);      // 7 - MIN wraps
        send_command(rsc_pkg::OP_ALL, '0);
        send_command(rsc_pkg::OP_CLEAR, '0);
        send_command(rsc_pkg::OP_TOP, '0);
    endtask

    // Random command mix weighted to keep the stack populated, with fill bursts.
    task automatic test_random_mix(input int num_items);
        int base;
        int pick;
        base = items_sent;
        fill_stack();
        while (items_sent - base < num_items)
        begin
            pick = $urandom_range(99);
            if (pick < 3)
                fill_stack();
            else if (pick < 31)
                send_command(rsc_pkg::OP_PUSH, pick_value());
            else if (pick < 39)
                send_command($urandom_range(1) ? rsc_pkg::OP_TOP : rsc_pkg::OP_POP,
                             $urandom());
            else if (pick < 44)
                send_command(rsc_pkg::OP_ALL, $urandom());
            else if (pick < 47)
                send_command(rsc_pkg::OP_CLEAR, $urandom());
            else if (pick < 55)
                send_command(rsc_pkg::OP_DUP, $urandom());
            else if (pick < 61)
                send_command(rsc_pkg::OP_SWAP, $urandom());
            else if (pick < 93)
                send_command(rsc_pkg::OP_ADD + 4'($urandom_range(4)), $urandom());
            else
                send_command(4'($urandom_range(OP_SPARE_HI, OP_SPARE_LO)), $urandom());
        end
    endtask

    initial
    begin
        int drain;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_idle_pct = 12;
        test_empty_stack();
        test_wrap_and_min_divide();
        test_divide_by_zero();
        test_signed_ops();
        test_random_mix(84);

        sender_idle_pct = 54;
        test_random_mix(84);

        sender_idle_pct = 0;
        test_random_mix(84);

        // Drain outstanding results, then allow the longest latency to pass.
        start <= 1'b0;
        drain = 0;
        while (expected_results.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch("results never arrived, count", expected_results.size(), '0);

        $display("Ran %0d commands over three idle settings; checked %0d results,",
                 items_sent, results_checked);
        $display("%0d with error status; stack filled to depth %0d %0d times; %0d mismatches.",
                 error_results, DEPTH, fill_bursts, error_count);
        if (error_count == 0)
            $display("rpn_stack_calculator test passed");
        else
            $display("rpn_stack_calculator test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
src/rsc_pkg.sv
src/rsc_div.sv
src/rsc_datapath.sv
src/rsc_ctrl.sv
src/rpn_stack_calculator.sv
verif/tb_rpn_stack_calculator.sv
